// ----- rtl/h264dpk_pkg.sv -----
// package for the h264 rtp depacketizer
// nal type codes, start code constants and the command passed from front to back
package h264dpk_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [4:0] NAL_TYPE_MASK_W = 5'h1f;
	localparam logic [4:0] NAL_IDR         = 5'd5;
	localparam logic [4:0] NAL_SINGLE_MAX  = 5'd23;
	localparam logic [4:0] NAL_STAP_A      = 5'd24;
	localparam logic [4:0] NAL_FU_A        = 5'd28;
	localparam logic [7:0] FU_NRI_MASK     = 8'he0;
	localparam logic [7:0] START_CODE_LAST = 8'h01;
	localparam logic [2:0] START_CODE_POS  = 3'd3;

	// one step of work for the back end: optional start code, optional byte, end info
	typedef struct packed {
		logic        sc;
		logic        hb;
		logic [7:0]  data;
		logic        pend;
		logic [17:0] total;
		logic        idr;
	} cmd_t;

endpackage

// ----- rtl/h264dpk_if.sv -----
// channel interfaces for the h264 rtp depacketizer
// input carries payload bytes, output carries annex-b bytes and end reports
interface h264dpk_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        first;
	logic        last;
	logic [15:0] packet_len;

	modport source(output valid, data_byte, first, last, packet_len, input ready);
	modport sink(input valid, data_byte, first, last, packet_len, output ready);
endinterface

interface h264dpk_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic        packet_end;
	logic [17:0] out_total;
	logic        idr_seen;

	modport source(output valid, out_byte, byte_valid, packet_end, out_total, idr_seen,
		input ready);
	modport sink(input valid, out_byte, byte_valid, packet_end, out_total, idr_seen,
		output ready);
endinterface

// ----- rtl/h264dpk_front.sv -----
// front end: accepts payload bytes, tracks packet state, builds commands
// depends on h264dpk_pkg and h264dpk_in_if
module h264dpk_front
	import h264dpk_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	h264dpk_in_if.sink   in_ch,
	input  logic         q_ready,
	output logic         q_push,
	output cmd_t         q_cmd
);

	typedef enum logic [1:0] {
		KIND_SINGLE = 2'd0,
		KIND_STAP   = 2'd1,
		KIND_FU     = 2'd2,
		KIND_IGNORE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		PH_SIZE_HI = 2'd0,
		PH_SIZE_LO = 2'd1,
		PH_DATA    = 2'd2,
		PH_REST    = 2'd3
	} phase_t;

	logic [15:0] bytes_left_q, bytes_left_d;
	kind_t       kind_q, kind_d;
	logic [7:0]  header_q, header_d;
	phase_t      phase_q, phase_d;
	logic [15:0] unit_left_q, unit_left_d;
	logic [7:0]  size_high_q, size_high_d;
	logic        idr_q, idr_d;
	logic [17:0] count_q, count_d;
	logic [1:0]  byte_pos_q, byte_pos_d;

	logic        accept;
	logic        act;
	logic        ending;
	logic [15:0] rem;
	logic [15:0] size;
	logic [4:0]  hdr_type;
	logic [17:0] count_base;
	logic        sc;
	logic        hb;
	logic [7:0]  data;

	assign in_ch.ready = q_ready;
	assign accept = in_ch.valid && in_ch.ready;
	assign hdr_type = in_ch.data_byte[4:0] & NAL_TYPE_MASK_W;
	assign size = {size_high_q, in_ch.data_byte};

	always_comb begin
		bytes_left_d = bytes_left_q;
		kind_d = kind_q;
		header_d = header_q;
		phase_d = phase_q;
		unit_left_d = unit_left_q;
		size_high_d = size_high_q;
		idr_d = idr_q;
		byte_pos_d = byte_pos_q;
		act = 1'b0;
		rem = '0;
		sc = 1'b0;
		hb = 1'b0;
		data = in_ch.data_byte;
		count_base = count_q;
		if (in_ch.first) begin
			act = 1'b1;
			// zero length counts as one byte
			rem = (in_ch.packet_len == 16'd0) ? 16'd0 : in_ch.packet_len - 16'd1;
			count_base = '0;
			idr_d = (hdr_type == NAL_IDR);
			phase_d = PH_SIZE_HI;
			unit_left_d = '0;
			size_high_d = '0;
			byte_pos_d = 2'd0;
			header_d = '0;
			if (hdr_type >= 5'd1 && hdr_type <= NAL_SINGLE_MAX) begin
				kind_d = KIND_SINGLE;
				sc = 1'b1;
				hb = 1'b1;
			end else if (hdr_type == NAL_STAP_A) begin
				kind_d = KIND_STAP;
			end else if (hdr_type == NAL_FU_A) begin
				kind_d = KIND_FU;
				header_d = in_ch.data_byte;
				byte_pos_d = 2'd1;
			end else begin
				kind_d = KIND_IGNORE;
			end
		end else if (bytes_left_q != 16'd0) begin
			act = 1'b1;
			rem = bytes_left_q - 16'd1;
			case (kind_q)
				KIND_SINGLE: begin
					hb = 1'b1;
				end
				KIND_STAP: begin
					case (phase_q)
						PH_SIZE_HI: begin
							size_high_d = in_ch.data_byte;
							phase_d = PH_SIZE_LO;
						end
						PH_SIZE_LO: begin
							if (size <= rem) begin
								sc = 1'b1;
								unit_left_d = size;
								if (size == 16'd0) begin
									phase_d = (rem > 16'd2) ? PH_SIZE_HI : PH_REST;
								end else begin
									phase_d = PH_DATA;
									byte_pos_d = 2'd1;
								end
							end else begin
								// oversize unit: drop the rest of the packet
								phase_d = PH_REST;
							end
						end
						PH_DATA: begin
							if (byte_pos_q == 2'd1) begin
								if (hdr_type == NAL_IDR) begin
									idr_d = 1'b1;
								end
								byte_pos_d = 2'd0;
							end
							hb = 1'b1;
							if (unit_left_q != 16'd0) begin
								unit_left_d = unit_left_q - 16'd1;
							end
							// two or fewer bytes left after a unit are padding
							if (unit_left_d == 16'd0) begin
								phase_d = (rem > 16'd2) ? PH_SIZE_HI : PH_REST;
							end
						end
						default: begin
						end
					endcase
				end
				KIND_FU: begin
					if (byte_pos_q == 2'd1) begin
						if (hdr_type == NAL_IDR) begin
							idr_d = 1'b1;
						end
						if (in_ch.data_byte[7]) begin
							sc = 1'b1;
							hb = 1'b1;
							data = (header_q & FU_NRI_MASK) | {3'b000, hdr_type};
						end
						byte_pos_d = 2'd2;
					end else begin
						hb = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		ending = act && (in_ch.last || rem == 16'd0);
		if (act) begin
			bytes_left_d = ending ? 16'd0 : rem;
		end
		count_d = count_base + (sc ? 18'd4 : 18'd0) + {17'd0, hb};
	end

	assign q_push = accept && (sc || hb || ending);

	always_comb begin
		q_cmd.sc = sc;
		q_cmd.hb = hb;
		q_cmd.data = data;
		q_cmd.pend = ending;
		q_cmd.total = ending ? count_d : 18'd0;
		q_cmd.idr = ending ? idr_d : 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			kind_q <= KIND_SINGLE;
			header_q <= '0;
			phase_q <= PH_SIZE_HI;
			unit_left_q <= '0;
			size_high_q <= '0;
			idr_q <= 1'b0;
			count_q <= '0;
			byte_pos_q <= '0;
		end else if (accept && act) begin
			bytes_left_q <= bytes_left_d;
			kind_q <= kind_d;
			header_q <= header_d;
			phase_q <= phase_d;
			unit_left_q <= unit_left_d;
			size_high_q <= size_high_d;
			idr_q <= idr_d;
			count_q <= count_d;
			byte_pos_q <= byte_pos_d;
		end
	end

endmodule

// ----- rtl/h264dpk_queue.sv -----
// command queue between front and back end
// depends on h264dpk_pkg for the command type
module h264dpk_queue
	import h264dpk_pkg::*;
#(
	parameter int Depth = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	output logic not_full,
	input  logic pop,
	output cmd_t rdata,
	output logic not_empty
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	cmd_t            mem_q [Depth];
	logic [PtrW-1:0] wptr_q, rptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push, do_pop;

	assign not_full = (count_q != CntW'(Depth));
	assign not_empty = (count_q != '0);
	assign do_push = push && not_full;
	assign do_pop = pop && not_empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/h264dpk_back.sv -----
// back end: expands each command into output bytes, one transfer per cycle while the output is not stalled
// depends on h264dpk_pkg and h264dpk_out_if
module h264dpk_back
	import h264dpk_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  cmd_t          q_cmd,
	output logic          q_pop,
	h264dpk_out_if.source out_ch
);

	logic [2:0]  pos_q;
	logic [2:0]  last_pos;
	logic        advance;
	logic        take;
	logic        at_last;
	logic        in_sc;
	logic [7:0]  item_byte;
	logic        item_valid;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        byte_valid_q;
	logic        packet_end_q;
	logic [17:0] out_total_q;
	logic        idr_seen_q;

	always_comb begin
		if (q_cmd.sc) begin
			last_pos = q_cmd.hb ? 3'd4 : START_CODE_POS;
		end else begin
			last_pos = 3'd0;
		end
		at_last = (pos_q == last_pos);
		in_sc = q_cmd.sc && (pos_q <= START_CODE_POS);
		if (in_sc) begin
			item_byte = (pos_q == START_CODE_POS) ? START_CODE_LAST : 8'h00;
			item_valid = 1'b1;
		end else if (q_cmd.hb) begin
			item_byte = q_cmd.data;
			item_valid = 1'b1;
		end else begin
			// bare end marker
			item_byte = 8'h00;
			item_valid = 1'b0;
		end
	end

	assign advance = !out_valid_q || out_ch.ready;
	assign take = advance && q_valid;
	assign q_pop = take && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			out_valid_q <= 1'b0;
			out_byte_q <= '0;
			byte_valid_q <= 1'b0;
			packet_end_q <= 1'b0;
			out_total_q <= '0;
			idr_seen_q <= 1'b0;
		end else if (take) begin
			pos_q <= at_last ? 3'd0 : pos_q + 3'd1;
			out_valid_q <= 1'b1;
			out_byte_q <= item_byte;
			byte_valid_q <= item_valid;
			packet_end_q <= at_last && q_cmd.pend;
			out_total_q <= (at_last && q_cmd.pend) ? q_cmd.total : 18'd0;
			idr_seen_q <= at_last && q_cmd.pend && q_cmd.idr;
		end else if (advance) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.out_byte = out_byte_q;
	assign out_ch.byte_valid = byte_valid_q;
	assign out_ch.packet_end = packet_end_q;
	assign out_ch.out_total = out_total_q;
	assign out_ch.idr_seen = idr_seen_q;

endmodule

// ----- rtl/h264_rtp_depacketizer_top.sv -----
// h264 rtp depacketizer: rtp payload bytes in, annex-b byte stream out
// an input byte's first result goes via the command queue and the back end's output
// register. throughput: one input byte per cycle while each causes at most one result
// and the output is not stalled; a byte that opens a unit (start code) yields its start
// code and any byte it carries at one result per cycle; the command queue absorbs short
// bursts. reset clears all packet state and empties the queue; no clearing pass is needed
module h264_rtp_depacketizer_top
	import h264dpk_pkg::*;
#(
	parameter int QueueDepth = QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	h264dpk_in_if.sink    in_ch,
	h264dpk_out_if.source out_ch
);

	logic q_push, q_ready, q_pop, q_valid;
	cmd_t q_wdata, q_rdata;

	h264dpk_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.q_ready (q_ready),
		.q_push  (q_push),
		.q_cmd   (q_wdata)
	);

	h264dpk_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wdata     (q_wdata),
		.not_full  (q_ready),
		.pop       (q_pop),
		.rdata     (q_rdata),
		.not_empty (q_valid)
	);

	h264dpk_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_cmd   (q_rdata),
		.q_pop   (q_pop),
		.out_ch  (out_ch)
	);

endmodule

// ----- tb/sv/tb_h264_rtp_depacketizer_top.sv -----
// testbench for the h264 rtp depacketizer: drives payload bytes, predicts the annex-b stream
// depends on h264dpk_pkg, the h264dpk_in_if/h264dpk_out_if interfaces and the rtl top
module tb_h264_rtp_depacketizer_top;
	import h264dpk_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD   = 10;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_BYTES = 195;
	localparam int TAIL_ITEMS   = 40;
	localparam int HOLD_AFTER   = 60;
	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 16;
	localparam int REPORT_MAX   = 10;

	localparam logic [4:0] NAL_SLICE = 5'd1;

	typedef enum logic [1:0] {PK_SINGLE, PK_STAP_A, PK_FU_A, PK_IGNORED} pkt_kind_e;
	typedef enum logic [1:0] {AG_SIZE_HI, AG_SIZE_LO, AG_UNIT_DATA, AG_SKIP} agg_phase_e;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        first;
		logic        last;
		logic [15:0] packet_len;
	} payload_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        byte_valid;
		logic        packet_end;
		logic [17:0] out_total;
		logic        idr_seen;
	} annexb_result_t;

	logic clk = 1'b0;
	logic arst_n;

	h264dpk_in_if  in_ch();
	h264dpk_out_if out_ch();

	h264_rtp_depacketizer_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	payload_item_t  payload_q[$];
	annexb_result_t annexb_expected[$];
	logic [7:0]     pkt_bytes[$];

	// depacketizer state as predicted
	logic [15:0] open_left;
	pkt_kind_e   cur_kind;
	logic [7:0]  frag_hdr_saved;
	agg_phase_e  stap_phase;
	logic [15:0] unit_remaining;
	logic [7:0]  size_msb;
	logic        idr_in_packet;
	logic [17:0] emitted_count;
	logic        awaiting_head;

	int   cycle_count = 0;
	int   payload_bytes_accepted = 0;
	int   packets_opened = 0;
	int   annexb_checked = 0;
	int   end_reports = 0;
	int   mismatch_count = 0;
	int   random_bytes = 0;
	logic in_taken = 1'b0;
	logic tail_mode = 1'b0;
	logic hold_active = 1'b0;
	int   src_gap = 0;
	int   sink_gap = 0;
	int   hold_left = 0;
	bit   hold_done = 1'b0;

	task automatic push_annexb_byte(input logic [7:0] b);
		annexb_result_t r;
		r = '0;
		r.out_byte = b;
		r.byte_valid = 1'b1;
		annexb_expected.push_back(r);
		emitted_count = emitted_count + 18'd1;
	endtask

	task automatic push_start_code();
		push_annexb_byte(8'h00);
		push_annexb_byte(8'h00);
		push_annexb_byte(8'h00);
		push_annexb_byte(START_CODE_LAST);
	endtask

	task automatic predict_annexb(input payload_item_t it);
		logic [4:0]     nal;
		logic [15:0]    plen;
		logic [15:0]    rem;
		logic [15:0]    unit_size;
		logic           ending;
		int             base;
		annexb_result_t r;
		base = annexb_expected.size();
		nal = it.data_byte[4:0] & NAL_TYPE_MASK_W;
		if (it.first) begin
			plen = (it.packet_len == 16'd0) ? 16'd1 : it.packet_len;
			rem = plen - 16'd1;
			emitted_count = '0;
			idr_in_packet = (nal == NAL_IDR);
			stap_phase = AG_SIZE_HI;
			unit_remaining = '0;
			size_msb = '0;
			awaiting_head = 1'b0;
			frag_hdr_saved = '0;
			if (nal >= 5'd1 && nal <= NAL_SINGLE_MAX) begin
				cur_kind = PK_SINGLE;
				push_start_code();
				push_annexb_byte(it.data_byte);
			end else if (nal == NAL_STAP_A) begin
				cur_kind = PK_STAP_A;
			end else if (nal == NAL_FU_A) begin
				cur_kind = PK_FU_A;
				frag_hdr_saved = it.data_byte;
				awaiting_head = 1'b1;
			end else begin
				cur_kind = PK_IGNORED;
			end
		end else begin
			// nothing open: byte is dropped without a trace
			if (open_left == 16'd0)
				return;
			rem = open_left - 16'd1;
			case (cur_kind)
				PK_SINGLE: push_annexb_byte(it.data_byte);
				PK_STAP_A: begin
					case (stap_phase)
						AG_SIZE_HI: begin
							size_msb = it.data_byte;
							stap_phase = AG_SIZE_LO;
						end
						AG_SIZE_LO: begin
							unit_size = {size_msb, it.data_byte};
							if (unit_size <= rem) begin
								push_start_code();
								unit_remaining = unit_size;
								if (unit_size == 16'd0) begin
									stap_phase = (rem > 16'd2) ? AG_SIZE_HI : AG_SKIP;
								end else begin
									stap_phase = AG_UNIT_DATA;
									awaiting_head = 1'b1;
								end
							end else begin
								stap_phase = AG_SKIP;
							end
						end
						AG_UNIT_DATA: begin
							if (awaiting_head) begin
								if (nal == NAL_IDR)
									idr_in_packet = 1'b1;
								awaiting_head = 1'b0;
							end
							push_annexb_byte(it.data_byte);
							if (unit_remaining != 16'd0)
								unit_remaining = unit_remaining - 16'd1;
							// two bytes or fewer after a unit are padding
							if (unit_remaining == 16'd0)
								stap_phase = (rem > 16'd2) ? AG_SIZE_HI : AG_SKIP;
						end
						default: ;
					endcase
				end
				PK_FU_A: begin
					if (awaiting_head) begin
						if (nal == NAL_IDR)
							idr_in_packet = 1'b1;
						if (it.data_byte[7]) begin
							push_start_code();
							push_annexb_byte((frag_hdr_saved & FU_NRI_MASK) | {3'b000, nal});
						end
						awaiting_head = 1'b0;
					end else begin
						push_annexb_byte(it.data_byte);
					end
				end
				default: ;
			endcase
		end
		ending = it.last || (rem == 16'd0);
		open_left = ending ? 16'd0 : rem;
		if (ending) begin
			if (annexb_expected.size() == base)
				r = '0;
			else
				r = annexb_expected.pop_back();
			r.packet_end = 1'b1;
			r.out_total = emitted_count;
			r.idr_seen = idr_in_packet;
			annexb_expected.push_back(r);
		end
	endtask

	task automatic queue_packet(input logic [15:0] plen, input bit mark_last);
		payload_item_t it;
		int i;
		for (i = 0; i < pkt_bytes.size(); i++) begin
			it.data_byte = pkt_bytes[i];
			it.first = (i == 0);
			it.last = mark_last && (i == pkt_bytes.size() - 1);
			// length field only counts with first, so scramble it elsewhere
			it.packet_len = (i == 0) ? plen : 16'($urandom_range(0, 16'hffff));
			payload_q.push_back(it);
		end
	endtask

	task automatic queue_stray(input int n);
		payload_item_t it;
		repeat (n) begin
			it.data_byte = 8'($urandom_range(0, 255));
			it.first = 1'b0;
			it.last = 1'($urandom_range(0, 1));
			it.packet_len = 16'($urandom_range(0, 16'hffff));
			payload_q.push_back(it);
		end
	endtask

	task automatic push_random_bytes(input int n);
		repeat (n)
			pkt_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic build_random_packet();
		int          sel;
		int          size;
		logic [7:0]  hdr;
		logic [7:0]  b;
		logic [4:0]  t;
		logic [15:0] usize;
		logic [15:0] plen;
		pkt_bytes.delete();
		sel = $urandom_range(0, 99);
		hdr = 8'($urandom_range(0, 255));
		if (sel < 30) begin
			t = 5'($urandom_range(1, NAL_SINGLE_MAX));
			hdr[4:0] = ($urandom_range(0, 3) == 0) ? NAL_IDR : t;
			pkt_bytes.push_back(hdr);
			push_random_bytes($urandom_range(0, 10));
		end else if (sel < 60) begin
			hdr[4:0] = NAL_STAP_A;
			pkt_bytes.push_back(hdr);
			repeat ($urandom_range(1, 3)) begin
				// now and then a size that cannot fit
				if ($urandom_range(0, 9) == 0)
					usize = 16'($urandom_range(0, 16'hffff));
				else
					usize = 16'($urandom_range(0, 6));
				pkt_bytes.push_back(usize[15:8]);
				pkt_bytes.push_back(usize[7:0]);
				if (usize != 16'd0) begin
					b = 8'($urandom_range(0, 255));
					if ($urandom_range(0, 2) == 0)
						b[4:0] = NAL_IDR;
					pkt_bytes.push_back(b);
					push_random_bytes((usize > 16'd6) ? 5 : int'(usize) - 1);
				end
			end
			push_random_bytes($urandom_range(0, 2));
		end else if (sel < 90) begin
			hdr[4:0] = NAL_FU_A;
			pkt_bytes.push_back(hdr);
			b = 8'($urandom_range(0, 255));
			t = 5'($urandom_range(1, NAL_SINGLE_MAX));
			if ($urandom_range(0, 3) != 0)
				b[4:0] = ($urandom_range(0, 2) == 0) ? NAL_IDR : t;
			if ($urandom_range(0, 7) != 0)
				pkt_bytes.push_back(b);
			push_random_bytes($urandom_range(0, 10));
		end else begin
			do
				t = 5'($urandom_range(0, 31));
			while ((t >= 5'd1 && t <= NAL_SINGLE_MAX) || t == NAL_STAP_A || t == NAL_FU_A);
			hdr[4:0] = t;
			pkt_bytes.push_back(hdr);
			push_random_bytes($urandom_range(0, 5));
		end
		size = pkt_bytes.size();
		random_bytes += size;
		sel = $urandom_range(0, 99);
		if (sel < 65) begin
			queue_packet(16'(size), 1'b1);
		end else if (sel < 75) begin
			plen = 16'(size + $urandom_range(1, 65535 - size));
			queue_packet(plen, 1'b1);
		end else if (sel < 85) begin
			queue_packet(16'(size), 1'b0);
		end else if (sel < 93) begin
			// length runs out early, the tail falls outside the packet
			plen = (size > 1) ? 16'($urandom_range(1, size - 1)) : 16'(size);
			queue_packet(plen, 1'b0);
		end else begin
			// left open, the next first drops it
			plen = 16'(size + $urandom_range(1, 1000));
			queue_packet(plen, 1'b0);
		end
		if ($urandom_range(0, 9) == 0)
			queue_stray($urandom_range(1, 3));
	endtask

	// sender: next item goes out when the current one has transferred
	always @(negedge clk) begin
		payload_item_t nxt;
		tail_mode <= (payload_q.size() < TAIL_ITEMS);
		if (arst_n && (!in_ch.valid || in_taken)) begin
			if (src_gap > 0) begin
				src_gap--;
				in_ch.valid <= 1'b0;
			end else if (payload_q.size() == 0) begin
				in_ch.valid <= 1'b0;
			end else if (!hold_active && !tail_mode && $urandom_range(0, 4) == 0) begin
				src_gap = $urandom_range(0, 5);
				in_ch.valid <= 1'b0;
			end else begin
				nxt = payload_q.pop_front();
				in_ch.data_byte <= nxt.data_byte;
				in_ch.first <= nxt.first;
				in_ch.last <= nxt.last;
				in_ch.packet_len <= nxt.packet_len;
				in_ch.valid <= 1'b1;
			end
		end
	end

	// receiver: random stall bursts plus one long hold to back up the block
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && payload_bytes_accepted >= HOLD_AFTER) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			hold_active <= (hold_left != 0);
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				out_ch.ready <= 1'b0;
			end else if (!tail_mode && $urandom_range(0, 4) == 0) begin
				sink_gap = $urandom_range(0, 5);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// input transfers feed the prediction, output transfers are checked against it
	always @(posedge clk) begin
		payload_item_t  it;
		annexb_result_t got;
		annexb_result_t want;
		cycle_count <= cycle_count + 1;
		in_taken <= arst_n && in_ch.valid && in_ch.ready;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			it.data_byte = in_ch.data_byte;
			it.first = in_ch.first;
			it.last = in_ch.last;
			it.packet_len = in_ch.packet_len;
			if (it.first)
				packets_opened++;
			payload_bytes_accepted++;
			predict_annexb(it);
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.out_byte = out_ch.out_byte;
			got.byte_valid = out_ch.byte_valid;
			got.packet_end = out_ch.packet_end;
			got.out_total = out_ch.out_total;
			got.idr_seen = out_ch.idr_seen;
			if (annexb_expected.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX)
					$display("%0t: unexpected output byte %h vld %b end %b total %0d idr %b",
						$realtime, got.out_byte, got.byte_valid, got.packet_end,
						got.out_total, got.idr_seen);
			end else begin
				want = annexb_expected.pop_front();
				annexb_checked++;
				if (want.packet_end)
					end_reports++;
				if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
					got.packet_end !== want.packet_end || got.out_total !== want.out_total ||
					got.idr_seen !== want.idr_seen) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("%0t: mismatch exp byte %h vld %b end %b total %0d idr %b, %s",
							$realtime, want.out_byte, want.byte_valid, want.packet_end,
							want.out_total, want.idr_seen,
							$sformatf("got byte %h vld %b end %b total %0d idr %b",
								got.out_byte, got.byte_valid, got.packet_end,
								got.out_total, got.idr_seen));
				end
			end
		end
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb_h264_rtp_depacketizer_top: done, errors");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.first = 1'b0;
		in_ch.last = 1'b0;
		in_ch.packet_len = '0;
		out_ch.ready = 1'b0;

		open_left = '0;
		cur_kind = PK_SINGLE;
		frag_hdr_saved = '0;
		stap_phase = AG_SIZE_HI;
		unit_remaining = '0;
		size_msb = '0;
		idr_in_packet = 1'b0;
		emitted_count = '0;
		awaiting_head = 1'b0;

		// one-byte idr slice
		pkt_bytes = '{{3'b011, NAL_IDR}};
		queue_packet(16'd1, 1'b1);
		// zero length field acts as one byte
		pkt_bytes = '{{3'b010, NAL_SLICE}};
		queue_packet(16'd0, 1'b0);
		// type 31 is ignored, ends on last with a bare end marker
		pkt_bytes = '{8'hff};
		queue_packet(16'hffff, 1'b1);
		// stap-a: unit, empty unit, unit, then two padding bytes
		pkt_bytes = '{{3'b011, NAL_STAP_A}, 8'h00, 8'h01, {3'b011, NAL_IDR}, 8'h00, 8'h00,
			8'h00, 8'h01, {3'b010, NAL_SLICE}, 8'h00, 8'h00};
		queue_packet(16'd11, 1'b1);
		// stap-a unit larger than the rest of the packet
		pkt_bytes = '{{3'b000, NAL_STAP_A}, 8'hff, 8'hff};
		queue_packet(16'd3, 1'b0);
		// fu-a start fragment rebuilds the header
		pkt_bytes = '{{3'b011, NAL_FU_A}, {1'b1, 2'b00, NAL_IDR}, 8'h11};
		queue_packet(16'd3, 1'b1);
		// fu-a cut before its fu header
		pkt_bytes = '{{3'b010, NAL_FU_A}};
		queue_packet(16'd1, 1'b1);
		// fu-a middle fragment
		pkt_bytes = '{{3'b010, NAL_FU_A}, {3'b000, NAL_IDR}};
		queue_packet(16'd2, 1'b1);
		queue_stray(1);
		// unfinished packet dropped by a new first
		pkt_bytes = '{{3'b010, NAL_SLICE}, 8'h01};
		queue_packet(16'd5, 1'b0);
		pkt_bytes = '{{3'b011, NAL_SLICE}, 8'h02};
		queue_packet(16'd2, 1'b1);

		while (random_bytes < RANDOM_BYTES)
			build_random_packet();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (payload_q.size() != 0 || in_ch.valid)
			@(posedge clk);
		while (annexb_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d payload bytes over %0d packets, %0d annex-b results checked",
			payload_bytes_accepted, packets_opened, annexb_checked);
		$display("%0d end reports seen, %0d mismatches", end_reports, mismatch_count);
		if (mismatch_count == 0)
			$display("tb_h264_rtp_depacketizer_top: done, clean");
		else
			$display("tb_h264_rtp_depacketizer_top: done, errors");
		$finish;
	end

endmodule
